// ----- hw/rtl/gaf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaf_pkg
// Shared types and codes for the group address filter.
// ----------------------------------------------------------------------------
package gaf_pkg;

    localparam int ADDR_W      = 8;
    localparam int ACTION_W    = 2;
    localparam int ENTRY_CNT_W = 4;
    localparam int CFG_INDEX_W = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CHECK  = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDR   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BCAST_ADDR = 4'd1;

    // operation broadcast to every cell during a sweep
    typedef struct packed {
        action_t             action;
        logic [ADDR_W-1:0]   addr;
    } gaf_op_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SWEEP  = 2'd1,
        ST_COMMIT = 2'd2
    } gaf_state_t;

endpackage

// ----- hw/rtl/gaf_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaf_cell
// One group list slot; compares, appends or shifts when the sweep token passes.
// ----------------------------------------------------------------------------
module gaf_cell #(
    parameter int IDX = 0,
    parameter int CW  = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tok_in,
    input  logic                        hit_in,
    input  gaf_pkg::gaf_op_t            op,
    input  logic [CW-1:0]               count,
    input  logic [gaf_pkg::ADDR_W-1:0]  next_entry,
    output logic [gaf_pkg::ADDR_W-1:0]  entry,
    output logic                        tok_out,
    output logic                        hit_out
);
    import gaf_pkg::*;

    logic [ADDR_W-1:0] entry_reg;
    logic [ADDR_W-1:0] entry_next;
    logic              tok_reg;
    logic              hit_reg;
    logic              hit_next;
    logic              live;
    logic              match;

    assign live     = (count > CW'(IDX));
    assign match    = live && (entry_reg == op.addr);
    assign hit_next = hit_in || match;

    always_comb
    begin
        entry_next = entry_reg;
        if (tok_in)
        begin
            case (op.action)
                ACT_ADD:
                begin
                    if (count == CW'(IDX))
                    begin
                        entry_next = op.addr;
                    end
                end
                ACT_REMOVE:
                begin
                    // first match here or upstream: pull in the neighbor's entry
                    if (hit_next)
                    begin
                        entry_next = next_entry;
                    end
                end
                default:
                begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
            hit_reg <= tok_in && hit_next;
        end
    end

    assign entry   = entry_reg;
    assign tok_out = tok_reg;
    assign hit_out = hit_reg;

endmodule

// ----- hw/rtl/group_address_filter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_address_filter_top
// Destination address filter with a shiftable list of group addresses.
// ----------------------------------------------------------------------------
// One item is handled at a time. A token walks the row of TABLE_DEPTH cells
// and is registered in each cell. Each cell compares its entry against the
// item address and, on a remove, pulls in its right neighbor's entry once
// the first match has been seen. When the token leaves the last cell, the
// row's hit flag is latched and the sequencer enters its commit state, which
// commits the count and loads the result register. The next item can be
// taken in the cycle after the commit. The result register decouples the
// output, so the next item is taken while a result still waits for
// m_tready. A commit waits only while the previous result is still held.
// Configuration writes are always ready and must only happen while no item
// is in flight. List entries carry no reset; only entries below the count
// are ever compared.
// ----------------------------------------------------------------------------
module group_address_filter_top #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,    // [7:0] addr
    input  logic [1:0]                      s_tuser,    // [1:0] action
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,    // [0] accepted, [1] done_ok,
                                                        // [5:2] entry_count, [7:6] zero
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gaf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gaf_pkg::ADDR_W-1:0]      cfg_data
);
    import gaf_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    gaf_state_t        state_reg;
    gaf_state_t        state_next;

    logic [ADDR_W-1:0] own_addr_reg;
    logic [ADDR_W-1:0] bcast_addr_reg;
    gaf_op_t           op_reg;
    logic              start_reg;
    logic              hit_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    logic              m_valid_reg;
    logic              res_accepted_reg;
    logic              res_done_reg;
    logic [ENTRY_CNT_W-1:0] res_count_reg;

    logic              in_accept;
    logic              commit_en;
    logic              sweep_done;
    logic              res_accepted;
    logic              res_done;
    logic [CW+ENTRY_CNT_W-1:0] count_ext;

    // cell row wiring
    logic [ADDR_W-1:0] entry_w [TABLE_DEPTH];
    logic [TABLE_DEPTH:0] tok_w;
    logic [TABLE_DEPTH:0] hit_w;

    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg   <= '0;
            bcast_addr_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OWN_ADDR:   own_addr_reg   <= cfg_data;
                CFG_BCAST_ADDR: bcast_addr_reg <= cfg_data;
                default:        ;   // unmapped index, ignored
            endcase
        end
    end

    // ---------------- item capture ----------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg.action <= action_t'(s_tuser);
            op_reg.addr   <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= in_accept;
        end
    end

    // ---------------- cell row ----------------
    assign tok_w[0] = start_reg;
    assign hit_w[0] = 1'b0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [ADDR_W-1:0] nbr;
        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign nbr = entry_w[i];
        end
        else
        begin : g_mid
            assign nbr = entry_w[i+1];
        end

        gaf_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .tok_in     (tok_w[i]),
            .hit_in     (hit_w[i]),
            .op         (op_reg),
            .count      (count_reg),
            .next_entry (nbr),
            .entry      (entry_w[i]),
            .tok_out    (tok_w[i+1]),
            .hit_out    (hit_w[i+1])
        );
    end

    assign sweep_done = tok_w[TABLE_DEPTH];

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_accept)  state_next = ST_SWEEP;
            ST_SWEEP:  if (sweep_done) state_next = ST_COMMIT;
            ST_COMMIT: if (commit_en)  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        commit_en = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready  = 1'b1;
            ST_COMMIT: commit_en = !m_valid_reg || m_tready;
            default:
            begin
                s_tready  = 1'b0;
                commit_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (sweep_done)
            begin
                hit_reg <= hit_w[TABLE_DEPTH];
            end
        end
    end

    // ---------------- result and count update ----------------
    always_comb
    begin
        res_accepted = 1'b0;
        res_done     = 1'b0;
        count_next   = count_reg;
        case (op_reg.action)
            ACT_CHECK:
            begin
                res_accepted = hit_reg || (op_reg.addr == bcast_addr_reg)
                               || (op_reg.addr == own_addr_reg);
            end
            ACT_ADD:
            begin
                if (count_reg < CW'(TABLE_DEPTH))
                begin
                    res_done   = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_REMOVE:
            begin
                if (hit_reg)
                begin
                    res_done   = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            default:    // clear
            begin
                res_done   = 1'b1;
                count_next = '0;
            end
        endcase
    end

    assign count_ext = {{ENTRY_CNT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit_en)
            begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_en)
        begin
            res_accepted_reg <= res_accepted;
            res_done_reg     <= res_done;
            res_count_reg    <= count_ext[ENTRY_CNT_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, res_count_reg, res_done_reg, res_accepted_reg};

endmodule

// ----- hw/rtl/gaf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaf_checker
// Port-level checks for the group address filter, bound to the top level.
// ----------------------------------------------------------------------------
module gaf_checker #(
    parameter int TABLE_DEPTH = 8
) (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // one item in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken back to back");

    // a result never flags both a check hit and a list update
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("accepted and done_ok both set");

    // count never exceeds the list size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((TABLE_DEPTH >= 15) || (m_tdata[5:2] <= 4'(TABLE_DEPTH))))
        else $error("entry count out of range");

    // zero padding above the count
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:6] == 2'b00))
        else $error("result padding not zero");

endmodule

bind group_address_filter_top gaf_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_gaf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for group_address_filter_top: streams check, add,
// remove and clear items with random gaps on both sides and compares every
// result against a software copy of the group list and address registers.
// ----------------------------------------------------------------------------
module tb_top;
    import gaf_pkg::*;

    localparam int TABLE_DEPTH = 8;
    // extra wait at the end of settle(), scaled with the list size
    localparam int ITEM_LATENCY = TABLE_DEPTH + 2;
    // cycles with no handshake at all before the run is declared hung
    localparam int STALL_LIMIT = 1000;
    localparam int MAX_GAP = 17;
    localparam int PHASE_ITEMS = 300;
    // small address pool so adds, removes and checks keep hitting each other
    localparam logic [ADDR_W-1:0] POOL_BASE = 8'h40;
    localparam int POOL_SIZE = 6;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_INDEX = {CFG_INDEX_W{1'b1}};

    // one result item as it should come out of the block
    typedef struct packed {
        logic                   accepted;
        logic                   done_ok;
        logic [ENTRY_CNT_W-1:0] entry_count;
    } verdict_t;

    // ------------------------------------------------------------------------
    // Filter model and scoreboard: mirrors the list and the two address
    // registers, queues the verdict of every accepted item, checks results.
    // ------------------------------------------------------------------------
    class addr_filter_model;
        logic [ADDR_W-1:0] own_addr;
        logic [ADDR_W-1:0] bcast_addr;
        logic [ADDR_W-1:0] groups[$];
        verdict_t          due_verdicts[$];
        int                errors;

        function new();
            own_addr   = '0;
            bcast_addr = '1;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [ADDR_W-1:0] val);
            if (idx == CFG_OWN_ADDR)
                own_addr = val;
            else if (idx == CFG_BCAST_ADDR)
                bcast_addr = val;
        endfunction

        function void note_item(action_t act, logic [ADDR_W-1:0] addr);
            verdict_t v;
            int       hit;
            v   = '0;
            hit = -1;
            for (int i = 0; i < groups.size(); i++)
                if (hit < 0 && groups[i] == addr)
                    hit = i;
            case (act)
                ACT_CHECK:
                    v.accepted = (addr == bcast_addr) || (addr == own_addr) || (hit >= 0);
                ACT_ADD:
                    if (groups.size() < TABLE_DEPTH)
                    begin
                        groups.insert(groups.size(), addr);
                        v.done_ok = 1'b1;
                    end
                ACT_REMOVE:
                    if (hit >= 0)
                    begin
                        // first match goes, later entries close the gap
                        groups.delete(hit);
                        v.done_ok = 1'b1;
                    end
                default:
                begin
                    groups.delete();
                    v.done_ok = 1'b1;
                end
            endcase
            v.entry_count = ENTRY_CNT_W'(groups.size());
            due_verdicts.insert(due_verdicts.size(), v);
        endfunction

        function void check_verdict(logic [7:0] data);
            verdict_t v;
            if (due_verdicts.size() == 0)
            begin
                $error("result 0x%02h with no item waiting", data);
                errors++;
                return;
            end
            v = due_verdicts.pop_front();
            if (data[0] !== v.accepted)
            begin
                $error("accepted: expected %0d, got %0d", v.accepted, data[0]);
                errors++;
            end
            if (data[1] !== v.done_ok)
            begin
                $error("done_ok: expected %0d, got %0d", v.done_ok, data[1]);
                errors++;
            end
            if (data[5:2] !== v.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", v.entry_count, data[5:2]);
                errors++;
            end
            if (data[7:6] !== 2'b00)
            begin
                $error("pad: expected 0, got %0d", data[7:6]);
                errors++;
            end
        endfunction

        function int pending();
            return due_verdicts.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;    // [7:0] addr
    logic [1:0]             s_tuser;    // [1:0] action
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;    // [0] accepted, [1] done_ok, [5:2] entry_count
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]      cfg_data;

    addr_filter_model filter;
    bit               calm;         // no idling on either side while set
    int               idle_cycles;

    group_address_filter_top #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap before the next item on either side; zero during calm stretches.
    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: all handshakes are sampled at the rising edge, before any
    // nonblocking update of this edge lands. The result is checked before
    // a new item is noted, so a same-edge accept never satisfies itself.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                filter.check_verdict(m_tdata);
            if (s_tvalid && s_tready)
                filter.note_item(action_t'(s_tuser), s_tdata);
            if (cfg_valid && cfg_ready)
                filter.write_reg(cfg_index, cfg_data);
        end
    end

    // Watchdog: any stretch with no handshake on any channel counts.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles < STALL_LIMIT)
            idle_cycles <= idle_cycles + 1;
        else
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure per item, ready held through waits.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Valid stays high across back-to-back items; it only drops for a gap.
    task automatic send_item(action_t act, logic [ADDR_W-1:0] addr);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= addr;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid and wait until every result is back and the row is quiet.
    // One edge first, so the last accepted item has been noted.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (filter.pending() != 0)
            @(posedge clk);
        repeat (ITEM_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [ADDR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Both address registers, optionally followed by a write to an unused index.
    task automatic set_addresses(logic [ADDR_W-1:0] own, logic [ADDR_W-1:0] bcast,
                                 bit stray);
        write_reg(CFG_OWN_ADDR, own);
        write_reg(CFG_BCAST_ADDR, bcast);
        if (stray)
            write_reg(CFG_INDEX_W'($urandom_range(CFG_BCAST_ADDR + 1, CFG_LAST_INDEX)),
                      ADDR_W'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
    endtask

    function automatic action_t pick_action();
        int r;
        r = $urandom_range(0, 99);
        // adds outweigh removes so the list fills up and overflows often
        if (r < 38)
            return ACT_CHECK;
        else if (r < 70)
            return ACT_ADD;
        else if (r < 94)
            return ACT_REMOVE;
        return ACT_CLEAR;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return POOL_BASE + ADDR_W'($urandom_range(0, POOL_SIZE - 1));
        else if (r < 55 && filter.groups.size() > 0)
            return filter.groups[$urandom_range(0, filter.groups.size() - 1)];
        else if (r < 65)
            return filter.own_addr;
        else if (r < 72)
            return filter.bcast_addr;
        return ADDR_W'($urandom_range(0, 255));
    endfunction

    task automatic run_random(int count);
        for (int n = 0; n < count; n++)
        begin
            // re-decide every 64 items whether this stretch runs without gaps
            if (n % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_item(pick_action(), pick_addr());
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_CHECK;
        cfg_valid = 1'b0;
        cfg_index = CFG_OWN_ADDR;
        cfg_data  = '0;
        calm      = 1'b0;
        filter    = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset addresses, empty list, fill to full, overflow,
        // duplicates, absent removes, clear of non-empty and empty lists.
        send_item(ACT_CHECK, 8'h00);     // own address after reset
        send_item(ACT_CHECK, 8'hFF);     // broadcast after reset
        send_item(ACT_CHECK, 8'h21);
        send_item(ACT_REMOVE, 8'h21);    // remove from empty list
        send_item(ACT_CLEAR, 8'h00);     // clear of empty list still succeeds
        send_item(ACT_ADD, 8'h21);
        send_item(ACT_ADD, 8'h21);       // duplicate
        send_item(ACT_ADD, 8'h80);
        send_item(ACT_ADD, 8'h7F);
        send_item(ACT_ADD, 8'h01);
        send_item(ACT_ADD, 8'hFE);
        send_item(ACT_ADD, 8'h55);
        send_item(ACT_ADD, 8'hAA);       // list now full
        send_item(ACT_ADD, 8'h33);       // refused
        send_item(ACT_CHECK, 8'hAA);     // last entry
        send_item(ACT_CHECK, 8'h33);
        send_item(ACT_REMOVE, 8'h21);    // only the first duplicate goes
        send_item(ACT_CHECK, 8'h21);
        send_item(ACT_REMOVE, 8'h99);    // absent
        send_item(ACT_ADD, 8'h33);
        send_item(ACT_REMOVE, 8'hAA);
        send_item(ACT_CLEAR, 8'hFF);     // clear of a non-empty list
        send_item(ACT_CHECK, 8'h80);
        send_item(ACT_REMOVE, 8'h80);
        settle();

        // Random phases, each under its own register setting.
        set_addresses(8'hFF, 8'h00, 1'b1);   // both extremes, swapped
        run_random(PHASE_ITEMS);
        settle();
        set_addresses(POOL_BASE, POOL_BASE + 8'd1, 1'b0);   // collide with groups
        run_random(PHASE_ITEMS);
        settle();
        set_addresses(8'h5A, 8'h5A, 1'b1);   // own equals broadcast
        run_random(PHASE_ITEMS);
        settle();
        set_addresses(ADDR_W'($urandom_range(0, 255)), ADDR_W'($urandom_range(0, 255)),
                      1'b1);
        run_random(PHASE_ITEMS);
        settle();

        if (filter.errors == 0 && filter.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/gaf_pkg.sv
hw/rtl/gaf_cell.sv
hw/rtl/group_address_filter_top.sv
hw/rtl/gaf_checker.sv
test/tb_top.sv
